### rtl/sfps_pkg.sv
// sfps_pkg: shared types, constants and codes of the scan frame parse and steer unit
// no dependencies; imported by every other file of the block except sfps_ram

package sfps_pkg;

  // default table depth (scan points a frame can address)
  localparam int unsigned MaxDotsDef = 1024;

  // field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DotsW    = 11;
  localparam int unsigned SectW    = 10;
  localparam int unsigned IdxAccW  = 11;
  localparam int unsigned DistW    = 16;
  localparam int unsigned IdxOutW  = 10;
  localparam int unsigned DirW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // register reset values
  localparam logic [DotsW-1:0] DotsReset = 11'd640;
  localparam logic [SectW-1:0] LeftReset = 10'd213;
  localparam logic [SectW-1:0] FwdReset  = 10'd426;

  // saturation limits of the accumulators
  localparam logic [IdxAccW-1:0] IdxAccMax = 11'h7FF;
  localparam logic [DistW-1:0]   DistMax   = 16'hFFFF;

  // ascii characters
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_INDEX  = 2'd1,
    PH_DIST   = 2'd2
  } phase_e;

  // steering decision
  typedef enum logic [DirW-1:0] {
    DIR_FORWARD = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_STOP    = 2'd3
  } dir_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOTS_IN_USE = 2'd0,
    CFG_LEFT_END    = 2'd1,
    CFG_FORWARD_END = 2'd2
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_SCAN  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_EMIT  = 3'd4
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic sweep;
    logic scan_rd;
    logic best_clr;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/sfps_ifs.sv
// sfps_in_if / sfps_out_if: valid-ready channels of the byte input and the decision output
// depends on sfps_pkg for field widths

interface sfps_in_if
  import sfps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink   (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface sfps_out_if
  import sfps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DirW-1:0]    direction;
  logic [IdxOutW-1:0] best_index;
  logic [DistW-1:0]   best_distance;
  logic               bad_index_seen;

  modport source (output valid, output direction, output best_index, output best_distance,
                  output bad_index_seen, input ready);
  modport sink   (input valid, input direction, input best_index, input best_distance,
                  input bad_index_seen, output ready);
endinterface

### rtl/scan_frame_parse_and_steer_unit.sv
// scan_frame_parse_and_steer_unit: top level, controller plus datapath
// depends on sfps_pkg, sfps_ifs, sfps_ctrl, sfps_datapath (and sfps_ram below it)
//
// Usage
//   in_ch   : ascii bytes of a scan frame, one per transaction; frame_last marks the
//             final byte. A header line, then lines "<index> <distance>\n".
//   out_ch  : one decision transaction per frame (direction, best_index,
//             best_distance, bad_index_seen).
//   cfg_*   : write port for dots_in_use, left_end, forward_end (index 0, 1, 2),
//             written while no frame end is in flight.
// Timing
//   Ordinary bytes are taken one per cycle while in_ch.ready is high. The byte with
//   frame_last starts a sweep of the distance table through its single read port,
//   which also zeroes every entry; after the sweep and a drain state the result is
//   loaded when the output register is free; in_ch.ready returns as it turns valid.
//   After reset the table is zeroed by the same sweep, so in_ch.ready stays low until
//   that sweep ends; configuration writes are taken throughout.
//   The result sits in an output register: bytes of the next frame are taken while
//   it waits, and only the hand-off of the next result waits for the receiver.

module scan_frame_parse_and_steer_unit
  import sfps_pkg::*;
#(
  parameter int unsigned MaxDots = MaxDotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  sfps_in_if.sink             in_ch,
  sfps_out_if.source          out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  sfps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // datapath
  sfps_datapath #(
    .MaxDots (MaxDots)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // a new result appears only from the controller's hand-off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result valid without hand-off");

  // frame end stops intake and starts the table sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.frame_end |=> (cmd.sweep && cmd.scan_rd && !cmd.in_ready))
    else $error("frame end did not start the scan");

  // a zero maximum always steers to stop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.best_distance == '0) |-> (out_ch.direction == DIR_STOP))
    else $error("zero maximum without stop");

  // stop carries index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.direction == DIR_STOP) |-> (out_ch.best_index == '0))
    else $error("stop with non-zero index");

endmodule

### rtl/sfps_ram.sv
// sfps_ram: generic single-write, single-read ram with registered read data
// no dependencies

module sfps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sfps_ctrl.sv
// sfps_ctrl: controller state machine (reset clear, byte intake, table scan, result hand-off)
// depends on sfps_pkg for state, command and status types

module sfps_ctrl
  import sfps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        // zero the whole table after reset
        cmd_o.sweep = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.frame_end) begin
          cmd_o.best_clr = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read each entry for the search and zero it behind the read
        cmd_o.sweep   = 1'b1;
        cmd_o.scan_rd = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/sfps_datapath.sv
// sfps_datapath: config registers, ascii line parser, distance table, max search, output register
// depends on sfps_pkg, sfps_ifs and sfps_ram

module sfps_datapath
  import sfps_pkg::*;
#(
  parameter int unsigned MaxDots = MaxDotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  sfps_in_if.sink             in_ch,
  sfps_out_if.source          out_ch
);

  localparam int unsigned IdxW = $clog2(MaxDots);
  localparam int unsigned CmpW = IdxW + IdxAccW + 2;

  // configuration registers
  logic [DotsW-1:0] dots_q;
  logic [SectW-1:0] left_q, fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dots_q <= DotsReset;
      left_q <= LeftReset;
      fwd_q  <= FwdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DOTS_IN_USE: dots_q <= cfg_wdata_i[DotsW-1:0];
        CFG_LEFT_END:    left_q <= cfg_wdata_i[SectW-1:0];
        CFG_FORWARD_END: fwd_q  <= cfg_wdata_i[SectW-1:0];
        default: ;
      endcase
    end
  end

  // input transaction
  logic in_fire;
  assign in_ch.ready = cmd_i.in_ready;
  assign in_fire     = in_ch.valid & cmd_i.in_ready;

  // parser state
  phase_e             phase_q, phase_d;
  logic [IdxAccW-1:0] idx_q, idx_d;
  logic [DistW-1:0]   dist_q, dist_d;
  logic               bad_q, bad_d;
  logic               bad_res_q, bad_res_d;

  // decimal digit accumulation with saturation
  logic                 is_digit;
  logic [3:0]           digit;
  logic [ByteW-1:0]     byte_off;
  logic [IdxAccW+3:0]   idx_mul;
  logic [DistW+3:0]     dist_mul;
  logic [IdxAccW-1:0]   idx_sat;
  logic [DistW-1:0]     dist_sat;

  assign is_digit = (in_ch.rx_byte >= ChZero) && (in_ch.rx_byte <= ChNine);
  assign byte_off = in_ch.rx_byte - ChZero;
  assign digit    = byte_off[3:0];
  assign idx_mul  = ({4'b0, idx_q} << 3) + ({4'b0, idx_q} << 1) + (IdxAccW+4)'(digit);
  assign dist_mul = ({4'b0, dist_q} << 3) + ({4'b0, dist_q} << 1) + (DistW+4)'(digit);
  assign idx_sat  = (idx_mul > (IdxAccW+4)'(IdxAccMax)) ? IdxAccMax : idx_mul[IdxAccW-1:0];
  assign dist_sat = (dist_mul > (DistW+4)'(DistMax)) ? DistMax : dist_mul[DistW-1:0];

  // line commit: index in range of both the register and the table
  logic                      idx_ok;
  logic                      commit;
  logic [IdxW+IdxAccW-1:0]   idx_ext;
  assign idx_ok  = (idx_q < dots_q) && (CmpW'(idx_q) < CmpW'(MaxDots));
  assign idx_ext = (IdxW+IdxAccW)'(idx_q);

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    dist_d    = dist_q;
    bad_d     = bad_q;
    bad_res_d = bad_res_q;
    commit    = 1'b0;
    if (in_fire) begin
      unique case (phase_q)
        PH_INDEX: begin
          if (is_digit) begin
            idx_d = idx_sat;
          end else if (in_ch.rx_byte == ChSpace) begin
            phase_d = PH_DIST;
          end else if (in_ch.rx_byte == ChNewline) begin
            idx_d  = '0;
            dist_d = '0;
          end
        end
        PH_DIST: begin
          if (is_digit) begin
            dist_d = dist_sat;
          end else if (in_ch.rx_byte == ChNewline) begin
            commit  = idx_ok;
            bad_d   = bad_q | ~idx_ok;
            idx_d   = '0;
            dist_d  = '0;
            phase_d = PH_INDEX;
          end
        end
        default: begin
          // header line
          if (in_ch.rx_byte == ChNewline) begin
            idx_d   = '0;
            dist_d  = '0;
            phase_d = PH_INDEX;
          end
        end
      endcase
      // end of frame: keep the flag for the result, start the next frame afresh
      if (in_ch.frame_last) begin
        bad_res_d = bad_d;
        phase_d   = PH_HEADER;
        idx_d     = '0;
        dist_d    = '0;
        bad_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      idx_q     <= '0;
      dist_q    <= '0;
      bad_q     <= 1'b0;
      bad_res_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      dist_q    <= dist_d;
      bad_q     <= bad_d;
      bad_res_q <= bad_res_d;
    end
  end

  // sweep counter over the whole table
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            cnt_last;
  assign cnt_last = (cnt_q == IdxW'(MaxDots - 1));
  assign cnt_d    = cnt_last ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q <= cnt_d;
    end
  end

  // distance table write port: sweep zeroes, parser commits
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [DistW-1:0] ram_wdata;
  logic [DistW-1:0] ram_rdata;

  always_comb begin
    if (cmd_i.sweep) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = commit;
      ram_waddr = idx_ext[IdxW-1:0];
      ram_wdata = dist_q;
    end
  end

  sfps_ram #(
    .Width (DistW),
    .Depth (MaxDots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // read data tracking for the search
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
  end

  // running maximum, first index wins on ties
  logic [DistW-1:0] best_d_q;
  logic [IdxW-1:0]  best_i_q;
  logic             in_limit;
  assign in_limit = CmpW'(rd_idx_q) < CmpW'(dots_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_clr) begin
      best_d_q <= '0;
      best_i_q <= '0;
    end else if (rd_vld_q && in_limit && (ram_rdata > best_d_q)) begin
      best_d_q <= ram_rdata;
      best_i_q <= rd_idx_q;
    end
  end

  // sector decision
  dir_e                 dir_d;
  logic [IdxW+IdxOutW-1:0] best_ext;
  assign best_ext = (IdxW+IdxOutW)'(best_i_q);

  always_comb begin
    if (best_d_q == '0) begin
      dir_d = DIR_STOP;
    end else if (CmpW'(best_i_q) <= CmpW'(left_q)) begin
      dir_d = DIR_LEFT;
    end else if (CmpW'(best_i_q) <= CmpW'(fwd_q)) begin
      dir_d = DIR_FORWARD;
    end else begin
      dir_d = DIR_RIGHT;
    end
  end

  // output register
  logic               out_vld_q;
  dir_e               dir_q;
  logic [IdxOutW-1:0] out_idx_q;
  logic [DistW-1:0]   out_dist_q;
  logic               out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      dir_q      <= dir_d;
      out_idx_q  <= best_ext[IdxOutW-1:0];
      out_dist_q <= best_d_q;
      out_bad_q  <= bad_res_q;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.direction      = dir_q;
  assign out_ch.best_index     = out_idx_q;
  assign out_ch.best_distance  = out_dist_q;
  assign out_ch.bad_index_seen = out_bad_q;

  // status to the controller
  assign status_o.frame_end = in_fire & in_ch.frame_last;
  assign status_o.cnt_last  = cnt_last;
  assign status_o.out_free  = ~out_vld_q | out_ch.ready;

endmodule

### test/testbench.sv
// testbench: random and directed scan frames into scan_frame_parse_and_steer_unit,
// decisions checked against a behavioural predictor kept in a small scoreboard class
// depends on sfps_pkg, sfps_ifs and the block's rtl
`timescale 1ns / 100ps

module testbench;
  import sfps_pkg::*;

  localparam int unsigned MaxDots    = MaxDotsDef;
  localparam int unsigned DrainWait  = MaxDots + 16;
  localparam int unsigned HoldCycles = 4000;
  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned ByteTarget = 1500;
  localparam int unsigned NumPhases  = 7;

  typedef struct packed {
    dir_e               dir;
    logic [IdxOutW-1:0] idx;
    logic [DistW-1:0]   best_dist;
    logic               bad;
  } decision_t;

  // scoreboard: parses accepted bytes, predicts the decision of each frame
  class steer_predictor;
    logic [DistW-1:0] dist_mem [MaxDots];
    phase_e           phase;
    int unsigned      idx_acc;
    int unsigned      dist_acc;
    bit               bad_line;
    logic [DotsW-1:0] dots;
    logic [SectW-1:0] left_lim;
    logic [SectW-1:0] fwd_lim;
    decision_t        pending[$];
    int unsigned      mismatches;

    function new();
      dots       = DotsReset;
      left_lim   = LeftReset;
      fwd_lim    = FwdReset;
      mismatches = 0;
      start_frame();
    endfunction

    function void start_frame();
      foreach (dist_mem[i]) dist_mem[i] = '0;
      phase    = PH_HEADER;
      idx_acc  = 0;
      dist_acc = 0;
      bad_line = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e r, logic [CfgDataW-1:0] v);
      case (r)
        CFG_DOTS_IN_USE: dots = v[DotsW-1:0];
        CFG_LEFT_END:    left_lim = v[SectW-1:0];
        CFG_FORWARD_END: fwd_lim = v[SectW-1:0];
        default: ;
      endcase
    endfunction

    // one accepted byte; a frame end adds a decision to the pending queue
    function void note_byte(logic [ByteW-1:0] c, logic last);
      bit          is_digit;
      int unsigned digit;
      int unsigned span;
      int unsigned i;
      decision_t   res;
      is_digit = (c >= ChZero) && (c <= ChNine);
      digit    = c - ChZero;
      case (phase)
        PH_INDEX: begin
          if (is_digit) begin
            idx_acc = idx_acc * 10 + digit;
            if (idx_acc > IdxAccMax) idx_acc = IdxAccMax;
          end else if (c == ChSpace) begin
            phase = PH_DIST;
          end else if (c == ChNewline) begin
            // line cut short before the separator: dropped
            idx_acc  = 0;
            dist_acc = 0;
          end
        end
        PH_DIST: begin
          if (is_digit) begin
            dist_acc = dist_acc * 10 + digit;
            if (dist_acc > DistMax) dist_acc = DistMax;
          end else if (c == ChNewline) begin
            if (idx_acc < dots && idx_acc < MaxDots) begin
              dist_mem[idx_acc] = dist_acc[DistW-1:0];
            end else begin
              bad_line = 1'b1;
            end
            idx_acc  = 0;
            dist_acc = 0;
            phase    = PH_INDEX;
          end
        end
        default: begin
          if (c == ChNewline) begin
            idx_acc  = 0;
            dist_acc = 0;
            phase    = PH_INDEX;
          end
        end
      endcase
      if (!last) return;

      // search for the largest entry, lowest index wins a tie
      span = (dots < MaxDots) ? dots : MaxDots;
      res  = '{dir: DIR_STOP, idx: '0, best_dist: '0, bad: bad_line};
      for (i = 0; i < span; i++) begin
        if (dist_mem[i] > res.best_dist) begin
          res.best_dist = dist_mem[i];
          res.idx       = IdxOutW'(i);
        end
      end
      if (res.best_dist == 0) res.dir = DIR_STOP;
      else if (res.idx <= left_lim) res.dir = DIR_LEFT;
      else if (res.idx <= fwd_lim) res.dir = DIR_FORWARD;
      else res.dir = DIR_RIGHT;
      pending.push_back(res);
      start_frame();
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (pending.size() == 0) begin
        $error("decision with none outstanding: direction %0d index %0d distance %0d",
               got.dir, got.idx, got.best_dist);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.dir !== want.dir) begin
        $error("direction: expected %0d, got %0d", want.dir, got.dir);
        mismatches++;
      end
      if (got.idx !== want.idx) begin
        $error("best_index: expected %0d, got %0d", want.idx, got.idx);
        mismatches++;
      end
      if (got.best_dist !== want.best_dist) begin
        $error("best_distance: expected %0d, got %0d", want.best_dist, got.best_dist);
        mismatches++;
      end
      if (got.bad !== want.bad) begin
        $error("bad_index_seen: expected %0d, got %0d", want.bad, got.bad);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sfps_in_if  in_ch ();
  sfps_out_if out_ch ();

  steer_predictor   steer;
  bit               calm;
  bit               hold_req;
  logic [ByteW-1:0] frame_q[$];

  scan_frame_parse_and_steer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // one byte transaction, with random idle cycles ahead of it
  task automatic push_byte(logic [ByteW-1:0] b, logic last);
    while (!calm && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.frame_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    steer.note_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) push_byte(frame_q[k], k == frame_q.size() - 1);
  endtask

  // quiet input, all decisions in, then room for a sweep still running
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (steer.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [CfgDataW-1:0] dots_v, logic [CfgDataW-1:0] left_v,
                              logic [CfgDataW-1:0] fwd_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DOTS_IN_USE;
    cfg_wdata_i <= dots_v;
    steer.set_reg(CFG_DOTS_IN_USE, dots_v);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LEFT_END;
    cfg_wdata_i <= left_v;
    steer.set_reg(CFG_LEFT_END, left_v);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FORWARD_END;
    cfg_wdata_i <= fwd_v;
    steer.set_reg(CFG_FORWARD_END, fwd_v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) frame_q.push_back(s[k]);
  endfunction

  // decimal digits, now and then with a leading zero
  function automatic void add_num(int unsigned n);
    if ($urandom_range(19) == 0) frame_q.push_back(ChZero);
    add_text($sformatf("%0d", n));
  endfunction

  function automatic logic [ByteW-1:0] header_byte();
    logic [ByteW-1:0] b;
    do b = $urandom_range(0, 255); while (b == ChNewline);
    return b;
  endfunction

  // mostly in range, some on sector bounds, some beyond the range in use
  function automatic int unsigned pick_index(int unsigned eff);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(99);
    if (r < 70 && eff != 0) return $urandom_range(0, eff - 1);
    if (r < 82) begin
      v = (r[0] ? steer.left_lim : steer.fwd_lim) + $urandom_range(0, 2);
      return (v == 0) ? 0 : v - 1;
    end
    if (r < 95) return $urandom_range(eff, 2047);
    return $urandom_range(2048, 99999);
  endfunction

  function automatic int unsigned pick_distance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 40) return $urandom_range(1, 20);
    if (r < 88) return $urandom_range(0, 65535);
    return $urandom_range(65536, 999999);
  endfunction

  // random frame: header, mostly well formed lines, some noise and broken lines
  function automatic void build_frame();
    int unsigned eff;
    int unsigned shape;
    frame_q = {};
    eff = (steer.dots < MaxDots) ? steer.dots : MaxDots;
    repeat ($urandom_range(0, 5)) frame_q.push_back(header_byte());
    if ($urandom_range(99) < 4) begin
      // frame ends inside the header
      frame_q.push_back(header_byte());
      return;
    end
    frame_q.push_back(ChNewline);
    repeat ($urandom_range(0, 9)) begin
      shape = $urandom_range(99);
      if (shape < 6) begin
        add_num(pick_index(eff));
        frame_q.push_back(ChNewline);
      end else if (shape < 9) begin
        frame_q.push_back(ChNewline);
      end else begin
        add_num(pick_index(eff));
        if (shape < 15) frame_q.push_back($urandom_range(0, 255));
        frame_q.push_back(ChSpace);
        if (shape >= 15 && shape < 22) frame_q.push_back(ChSpace);
        add_num(pick_distance());
        if (shape >= 15 && shape < 22) frame_q.push_back(ChSpace);
        if (shape >= 22 && shape < 28) frame_q.push_back($urandom_range(0, 255));
        frame_q.push_back(ChNewline);
      end
    end
    // how the frame ends: on a newline, mid line, or on a stray byte
    shape = $urandom_range(99);
    if (shape >= 70 && shape < 85) begin
      add_num(pick_index(eff));
      frame_q.push_back(ChSpace);
      add_num(pick_distance());
    end else if (shape >= 85) begin
      frame_q.push_back($urandom_range(0, 255));
    end
  endfunction

  // decision sink: checks each transaction, stalls at random, holds off once on request
  initial begin : decision_sink
    int unsigned hold_left;
    decision_t   got;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.dir       = dir_e'(out_ch.direction);
        got.idx       = out_ch.best_index;
        got.best_dist = out_ch.best_distance;
        got.bad       = out_ch.bad_index_seen;
        steer.check_decision(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HoldCycles;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned         p;
    int unsigned         phase_bytes;
    int unsigned         phase_frames;
    logic [CfgDataW-1:0] dots_v;
    logic [CfgDataW-1:0] left_v;
    logic [CfgDataW-1:0] fwd_v;
    steer            = new();
    calm             = 1'b0;
    hold_req         = 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_DOTS_IN_USE;
    cfg_wdata_i      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= '0;
    in_ch.frame_last <= 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset register values: empty frame gives stop
    frame_q = {};
    add_text("\n");
    send_frame();
    // extreme header bytes, saturated distance, line cut before space, noise in index
    frame_q = {8'hFF, 8'h00};
    add_text("\n4 9\n2 99999\n3\n1x 2 3\n");
    send_frame();
    // saturated index flagged, tie to the lower index, unfinished last line
    frame_q = {};
    add_text("\n99999 5\n5 7\n3 7\n12");
    send_frame();

    for (p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin dots_v = 11'd640;  left_v = 11'd213;  fwd_v = 11'd426;  end
        1: begin dots_v = 11'd1024; left_v = 11'd0;    fwd_v = 11'd1023; end
        2: begin dots_v = 11'd2047; left_v = 11'd1023; fwd_v = 11'd0;    end
        3: begin dots_v = 11'd1;    left_v = 11'd0;    fwd_v = 11'd0;    end
        4: begin dots_v = 11'd0;    left_v = 11'd5;    fwd_v = 11'd3;    end
        5: begin
          dots_v = $urandom_range(1, 1024);
          left_v = $urandom_range(0, 2047);
          fwd_v  = $urandom_range(0, 2047);
        end
        default: begin
          dots_v = $urandom_range(0, 2047);
          left_v = $urandom_range(0, 2047);
          fwd_v  = $urandom_range(0, 2047);
        end
      endcase
      program_regs(dots_v, left_v, fwd_v);
      // one phase without idling, one with a long receiver hold-off
      calm     = (p == 1);
      hold_req = (p == 2);
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < ByteTarget / NumPhases || phase_frames < 3) begin
        build_frame();
        phase_bytes += frame_q.size();
        phase_frames++;
        send_frame();
      end
    end
    calm = 1'b0;
    settle();

    if (steer.mismatches == 0 && steer.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
